// ----- sv/bsts_pkg.sv -----
// shared types, constants and a helper function for the balanced screen tile split
// no dependencies
package bsts_pkg;

  localparam int MAX_TILES_DEF = 64;
  localparam int DIM_BITS_DEF  = 14;

  localparam int COUNT_W  = 7;
  localparam int FRAME_W  = 14;
  localparam int INDEX_W  = 6;
  localparam int OFFSET_W = 13;
  localparam int SIZE_W   = 14;

  typedef struct packed {
    logic [COUNT_W-1:0] tile_count;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  tile_index;
    logic [OFFSET_W-1:0] tile_x;
    logic [OFFSET_W-1:0] tile_y;
    logic [SIZE_W-1:0]   tile_width;
    logic [SIZE_W-1:0]   tile_height;
    logic                last_tile;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_ROW_START,
    ST_WAIT_NUM,
    ST_WAIT_HGT,
    ST_COL_START,
    ST_WAIT_WID,
    ST_EMIT,
    ST_ROW_END
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_TILES,
    DIV_HEIGHT,
    DIV_WIDTH
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     sqrt_inc;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_in_row;
    logic     cap_row_h;
    logic     cap_tile;
    logic     row_end;
  } cmd_t;

  typedef struct packed {
    logic sqrt_more;
    logic rows_zero;
    logic cols_zero;
    logic div_done;
  } stat_t;

  // elaboration-time integer square root
  function automatic int isqrt_c(input int n);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

endpackage

// ----- sv/balanced_screen_tile_split_unit.sv -----
// Splits a frame into floor(sqrt(count)) rows of balanced tiles and emits one
// transaction per tile. Requests are taken one at a time; in_stall stays high
// from acceptance until the controller has passed ST_COL_START, ST_ROW_END and
// ST_ROW_START after the last tile has been taken. All divisions share one
// bit-serial divider of Q = max(DIM_BITS, clog2(MAX_TILES+1)) steps, and output
// stalls delay the point at which the next request can be taken. A zero tile
// count gives no transactions and returns to idle through ST_SQRT and ST_ROW_START.
// depends on bsts_pkg, bsts_ctrl, bsts_datapath
module balanced_screen_tile_split_unit #(
  parameter int MAX_TILES = bsts_pkg::MAX_TILES_DEF,
  parameter int DIM_BITS  = bsts_pkg::DIM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bsts_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bsts_pkg::out_item_t  out_data
);
  import bsts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bsts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsts_datapath #(
    .MAX_TILES(MAX_TILES),
    .DIM_BITS (DIM_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

endmodule

// ----- sv/bsts_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing outside this file
module bsts_div #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quo_next;

  always_comb begin
    trial    = {rem, quo[DIVIDEND_W-1]};
    ge       = (trial >= {1'b0, dsr});
    diff     = trial - {1'b0, dsr};
    rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_next = {quo[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ----- sv/bsts_datapath.sv -----
// working registers of the split, the shared divider and the result register
// depends on bsts_pkg and bsts_div
module bsts_datapath #(
  parameter int MAX_TILES = 64,
  parameter int DIM_BITS  = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bsts_pkg::in_item_t   in_data,
  input  bsts_pkg::cmd_t       cmd,
  output bsts_pkg::stat_t      stat,
  output bsts_pkg::out_item_t  out_data
);
  import bsts_pkg::*;

  localparam int TW      = $clog2(MAX_TILES + 1);
  localparam int RW      = $clog2(isqrt_c(MAX_TILES) + 1);
  localparam int DW      = DIM_BITS;
  localparam int QW      = (DW > TW) ? DW : TW;
  localparam int DimMax  = 2 ** (DIM_BITS - 1);

  logic [TW-1:0]      total;
  logic [TW-1:0]      tiles_rem;
  logic [TW-1:0]      cols;
  logic [TW-1:0]      in_row;
  logic [TW-1:0]      emitted;
  logic [RW-1:0]      rows;
  logic [DW-1:0]      fw;
  logic [DW-1:0]      hrem;
  logic [DW-1:0]      wrem;
  logic [DW-1:0]      offx;
  logic [DW-1:0]      offy;
  logic [DW-1:0]      row_h;
  logic [INDEX_W-1:0] tile_counter;
  out_item_t          out_q;

  logic [TW-1:0]      total_in;
  logic [DW-1:0]      fw_in;
  logic [DW-1:0]      fh_in;
  logic [RW:0]        rows_p1;
  logic [2*RW+1:0]    rows_sq;
  logic [QW-1:0]      div_a;
  logic [TW-1:0]      div_b;
  logic               div_done;
  logic [QW-1:0]      div_q;
  logic [DW-1:0]      w;

  // input saturation
  always_comb begin
    total_in = (32'(in_data.tile_count) > 32'(MAX_TILES)) ?
               TW'(MAX_TILES) : TW'(in_data.tile_count);
    fw_in    = (32'(in_data.frame_width) > 32'(DimMax)) ?
               DW'(DimMax) : DW'(in_data.frame_width);
    fh_in    = (32'(in_data.frame_height) > 32'(DimMax)) ?
               DW'(DimMax) : DW'(in_data.frame_height);
  end

  always_comb begin
    rows_p1 = {1'b0, rows} + (RW + 1)'(1);
    rows_sq = (2 * RW + 2)'(rows_p1) * (2 * RW + 2)'(rows_p1);
  end

  always_comb begin
    unique case (cmd.div_sel)
      DIV_TILES: begin
        div_a = QW'(tiles_rem);
        div_b = TW'(rows);
      end
      DIV_HEIGHT: begin
        div_a = QW'(hrem);
        div_b = TW'(rows);
      end
      DIV_WIDTH: begin
        div_a = QW'(wrem);
        div_b = cols;
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  bsts_div #(
    .DIVIDEND_W(QW),
    .DIVISOR_W (TW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_a),
    .divisor (div_b),
    .done    (div_done),
    .quotient(div_q)
  );

  assign w = DW'(div_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      tiles_rem    <= '0;
      cols         <= '0;
      in_row       <= '0;
      emitted      <= '0;
      rows         <= '0;
      fw           <= '0;
      hrem         <= '0;
      wrem         <= '0;
      offx         <= '0;
      offy         <= '0;
      row_h        <= '0;
      tile_counter <= '0;
      out_q        <= '0;
    end else begin
      if (cmd.load) begin
        total        <= total_in;
        tiles_rem    <= total_in;
        fw           <= fw_in;
        hrem         <= fh_in;
        offy         <= '0;
        tile_counter <= '0;
        emitted      <= '0;
        rows         <= '0;
      end
      if (cmd.sqrt_inc) begin
        rows <= rows + RW'(1);
      end
      if (cmd.cap_in_row) begin
        in_row <= TW'(div_q);
        cols   <= TW'(div_q);
      end
      if (cmd.cap_row_h) begin
        row_h <= DW'(div_q);
        wrem  <= fw;
        offx  <= '0;
      end
      if (cmd.cap_tile) begin
        out_q.tile_index  <= tile_counter;
        out_q.tile_x      <= OFFSET_W'(offx);
        out_q.tile_y      <= OFFSET_W'(offy);
        out_q.tile_width  <= SIZE_W'(w);
        out_q.tile_height <= SIZE_W'(row_h);
        out_q.last_tile   <= (({1'b0, emitted} + (TW + 1)'(1)) == {1'b0, total});
        offx              <= offx + w;
        wrem              <= wrem - w;
        cols              <= cols - TW'(1);
        tile_counter      <= tile_counter + INDEX_W'(1);
        emitted           <= emitted + TW'(1);
      end
      if (cmd.row_end) begin
        offy      <= offy + row_h;
        hrem      <= hrem - row_h;
        tiles_rem <= tiles_rem - in_row;
        rows      <= rows - RW'(1);
      end
    end
  end

  always_comb begin
    stat.sqrt_more = (32'(rows_sq) <= 32'(total));
    stat.rows_zero = (rows == '0);
    stat.cols_zero = (cols == '0);
    stat.div_done  = div_done;
  end

  assign out_data = out_q;

  a_tile_cols: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_tile |-> cols != '0)
    else $error("tile captured with no tiles left in the row");

  a_tile_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.cap_tile |-> QW'(wrem) >= div_q)
    else $error("tile width exceeds remaining row width");

  a_row_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.row_end |-> row_h <= hrem)
    else $error("row height exceeds remaining frame height");

endmodule

// ----- sv/bsts_ctrl.sv -----
// sequencing state machine: square root steps, row and tile divisions, output handshake
// depends on bsts_pkg
module bsts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  bsts_pkg::stat_t  stat,
  output bsts_pkg::cmd_t   cmd
);
  import bsts_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_SQRT;
      ST_SQRT:      if (!stat.sqrt_more) state_next = ST_ROW_START;
      ST_ROW_START: state_next = stat.rows_zero ? ST_IDLE : ST_WAIT_NUM;
      ST_WAIT_NUM:  if (stat.div_done) state_next = ST_WAIT_HGT;
      ST_WAIT_HGT:  if (stat.div_done) state_next = ST_COL_START;
      ST_COL_START: state_next = stat.cols_zero ? ST_ROW_END : ST_WAIT_WID;
      ST_WAIT_WID:  if (stat.div_done) state_next = ST_EMIT;
      ST_EMIT:      if (!out_stall) state_next = ST_COL_START;
      ST_ROW_END:   state_next = ST_ROW_START;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    cmd.load       = 1'b0;
    cmd.sqrt_inc   = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.div_sel    = DIV_TILES;
    cmd.cap_in_row = 1'b0;
    cmd.cap_row_h  = 1'b0;
    cmd.cap_tile   = 1'b0;
    cmd.row_end    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SQRT: begin
        cmd.sqrt_inc = stat.sqrt_more;
      end
      ST_ROW_START: begin
        cmd.div_start = !stat.rows_zero;
        cmd.div_sel   = DIV_TILES;
      end
      ST_WAIT_NUM: begin
        // tiles in this row known, start the row height division right away
        cmd.cap_in_row = stat.div_done;
        cmd.div_start  = stat.div_done;
        cmd.div_sel    = DIV_HEIGHT;
      end
      ST_WAIT_HGT: begin
        cmd.cap_row_h = stat.div_done;
      end
      ST_COL_START: begin
        cmd.div_start = !stat.cols_zero;
        cmd.div_sel   = DIV_WIDTH;
      end
      ST_WAIT_WID: begin
        cmd.div_sel  = DIV_WIDTH;
        cmd.cap_tile = stat.div_done;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
      end
      ST_ROW_END: begin
        cmd.row_end = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a tile is pending");

  a_tile_shown: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT_WID && stat.div_done) |=> out_valid)
    else $error("captured tile not presented");

  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !stat.div_done)
    else $error("divider finished too early");

endmodule
